@@ sv/mbq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbq_pkg
// Shared constants, types and helpers for the mboxrd "From " line quoter.
// ----------------------------------------------------------------------------
package mbq_pkg;

    localparam int MAX_QUOTE_DEPTH = 32;
    localparam int MAX_RESULTS     = 40;
    localparam int MATCH_LEN       = 5;

    localparam int QCNT_W = 6;
    localparam int PCNT_W = 3;
    localparam int RCNT_W = $clog2(MAX_RESULTS);

    localparam logic [7:0] CHAR_GT = 8'h3E;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Output schedule for one item, drained front to back
    typedef struct packed {
        logic              cr_en;
        logic [7:0]        cr_byte;
        logic              extra_en;
        logic [QCNT_W-1:0] q_cnt;
        logic              q_ovf;
        logic [PCNT_W-1:0] p_cnt;
        logic [PCNT_W-1:0] p_pos;
        logic              b_en;
        logic [7:0]        b_val;
        logic [1:0]        nl_cnt;
        logic              eom;
    } plan_t;

    function automatic logic [7:0] from_char(input logic [PCNT_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h46; // F
            3'd1:    c = 8'h72; // r
            3'd2:    c = 8'h6F; // o
            3'd3:    c = 8'h6D; // m
            3'd4:    c = 8'h20; // space
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic plan_empty(input plan_t p);
        return !p.cr_en && !p.extra_en && (p.q_cnt == '0) && (p.p_pos == p.p_cnt)
            && !p.b_en && (p.nl_cnt == 2'd0);
    endfunction

endpackage

@@ sv/mboxrd_from_line_quoter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mboxrd_from_line_quoter
// Quotes "From " lines (with any leading '>' run) in a message byte stream.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_ready | in_byte, end_of_message
//  out     | out_valid/out_ready | out_byte, run_last, message_done,
//          |                     | quote_overflow
//
//  An item is decoded in the cycle it is accepted into a schedule register;
//  unless the output stalls, the schedule drains one byte per cycle into the
//  output register. An item holds the schedule until its last byte moves out
//  (held bytes give none and never enter it), and the next item is accepted
//  in the cycle the last byte moves out, so plain text runs at one byte per
//  cycle while the output is not stalled. Output stalls back up through the
//  schedule register to in_ready. Reset returns the line state to start of line and empties both registers.
// ----------------------------------------------------------------------------
module mboxrd_from_line_quoter
    import mbq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_message,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       message_done,
    output logic       quote_overflow
);

    // Line state
    logic              line_start_reg, line_start_next;
    logic              cand_reg, cand_next;
    logic [QCNT_W-1:0] quote_cnt_reg, quote_cnt_next;
    logic [PCNT_W-1:0] match_reg, match_next;
    logic              cr_pend_reg, cr_pend_next;

    // Schedule and output stage
    plan_t             plan_reg;
    logic              plan_valid_reg;
    logic [RCNT_W-1:0] res_cnt_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              run_last_reg;
    logic              done_reg;
    logic              ovf_reg;

    plan_t             step_plan;
    plan_t             rest_plan;
    logic [7:0]        cur_byte;
    logic              cur_ovf;
    logic              move_last;
    logic              out_load;
    logic              accept;

    // ---------------------------------------------------------------- decode
    always_comb
    begin
        logic consumed;
        logic do_plain;
        step_plan         = '0;
        step_plan.cr_byte = CHAR_CR;
        step_plan.b_val   = in_byte;
        step_plan.eom     = end_of_message;
        line_start_next   = line_start_reg;
        cand_next         = cand_reg;
        quote_cnt_next    = quote_cnt_reg;
        match_next        = match_reg;
        cr_pend_next      = 1'b0;
        do_plain          = 1'b0;
        consumed          = cr_pend_reg && (in_byte == CHAR_LF);

        if (cr_pend_reg)
        begin
            step_plan.cr_en   = 1'b1;
            step_plan.cr_byte = consumed ? CHAR_LF : CHAR_CR;
            line_start_next   = consumed;
        end

        if (consumed)
        begin
            line_start_next = 1'b1;
        end
        else if ((line_start_reg && !cr_pend_reg) || cand_reg)
        begin
            line_start_next = 1'b0;
            if (match_reg == '0 && in_byte == CHAR_GT)
            begin
                if (quote_cnt_reg >= QCNT_W'(MAX_QUOTE_DEPTH))
                begin
                    // run too deep: out it goes, unquoted and flagged
                    step_plan.q_cnt = quote_cnt_reg + QCNT_W'(1);
                    step_plan.q_ovf = 1'b1;
                    quote_cnt_next  = '0;
                    cand_next       = 1'b0;
                end
                else
                begin
                    quote_cnt_next = quote_cnt_reg + QCNT_W'(1);
                    cand_next      = 1'b1;
                end
            end
            else if (match_reg < PCNT_W'(MATCH_LEN) && in_byte == from_char(match_reg))
            begin
                if (match_reg == PCNT_W'(MATCH_LEN - 1))
                begin
                    step_plan.extra_en = 1'b1;
                    step_plan.q_cnt    = quote_cnt_reg;
                    step_plan.p_cnt    = match_reg;
                    step_plan.b_en     = 1'b1;
                    quote_cnt_next     = '0;
                    match_next         = '0;
                    cand_next          = 1'b0;
                end
                else
                begin
                    match_next = match_reg + PCNT_W'(1);
                    cand_next  = 1'b1;
                end
            end
            else
            begin
                step_plan.q_cnt = quote_cnt_reg;
                step_plan.p_cnt = match_reg;
                quote_cnt_next  = '0;
                match_next      = '0;
                cand_next       = 1'b0;
                do_plain        = 1'b1;
            end
        end
        else
        begin
            do_plain = 1'b1;
        end

        if (do_plain)
        begin
            if (in_byte == CHAR_CR && !end_of_message)
            begin
                cr_pend_next = 1'b1;
            end
            else
            begin
                step_plan.b_en = 1'b1;
                if (in_byte == CHAR_LF)
                begin
                    line_start_next = 1'b1;
                end
            end
        end

        if (end_of_message)
        begin
            // anything still held goes out ahead of the closing newlines
            if (quote_cnt_next != '0 || match_next != '0)
            begin
                step_plan.q_cnt = quote_cnt_next;
                step_plan.p_cnt = match_next;
            end
            step_plan.nl_cnt = (in_byte == CHAR_LF) ? 2'd1 : 2'd2;
            line_start_next  = 1'b1;
            cand_next        = 1'b0;
            quote_cnt_next   = '0;
            match_next       = '0;
            cr_pend_next     = 1'b0;
        end
    end

    // ------------------------------------------------------------- serialiser
    always_comb
    begin
        rest_plan = plan_reg;
        cur_ovf   = 1'b0;
        priority if (plan_reg.cr_en)
        begin
            cur_byte        = plan_reg.cr_byte;
            rest_plan.cr_en = 1'b0;
        end
        else if (plan_reg.extra_en)
        begin
            cur_byte           = CHAR_GT;
            rest_plan.extra_en = 1'b0;
        end
        else if (plan_reg.q_cnt != '0)
        begin
            cur_byte        = CHAR_GT;
            cur_ovf         = plan_reg.q_ovf;
            rest_plan.q_cnt = plan_reg.q_cnt - QCNT_W'(1);
        end
        else if (plan_reg.p_pos != plan_reg.p_cnt)
        begin
            cur_byte        = from_char(plan_reg.p_pos);
            rest_plan.p_pos = plan_reg.p_pos + PCNT_W'(1);
        end
        else if (plan_reg.b_en)
        begin
            cur_byte       = plan_reg.b_val;
            rest_plan.b_en = 1'b0;
        end
        else
        begin
            cur_byte         = CHAR_LF;
            rest_plan.nl_cnt = plan_reg.nl_cnt - 2'd1;
        end
        move_last = plan_empty(rest_plan) || (res_cnt_reg == RCNT_W'(MAX_RESULTS - 1));
    end

    assign out_load = plan_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !plan_valid_reg || (out_load && move_last);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_start_reg <= 1'b1;
            cand_reg       <= 1'b0;
            quote_cnt_reg  <= '0;
            match_reg      <= '0;
            cr_pend_reg    <= 1'b0;
            plan_valid_reg <= 1'b0;
            res_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                line_start_reg <= line_start_next;
                cand_reg       <= cand_next;
                quote_cnt_reg  <= quote_cnt_next;
                match_reg      <= match_next;
                cr_pend_reg    <= cr_pend_next;
            end

            if (accept && !plan_empty(step_plan))
            begin
                plan_valid_reg <= 1'b1;
                res_cnt_reg    <= '0;
            end
            else if (out_load)
            begin
                plan_valid_reg <= !move_last;
                res_cnt_reg    <= res_cnt_reg + RCNT_W'(1);
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            plan_reg <= step_plan;
        end
        else if (out_load)
        begin
            plan_reg <= rest_plan;
        end

        if (out_load)
        begin
            out_byte_reg <= cur_byte;
            run_last_reg <= move_last;
            done_reg     <= move_last && plan_reg.eom;
            ovf_reg      <= cur_ovf;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign run_last       = run_last_reg;
    assign message_done   = done_reg;
    assign quote_overflow = ovf_reg;

endmodule

@@ sv/mbq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbq_checker
// Port-level checks for the "From " line quoter, bound to the top level.
// ----------------------------------------------------------------------------
module mbq_checker
    import mbq_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       message_done,
    input logic       quote_overflow
);

    // a stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
        else $error("output item changed while stalled");

    // a message always closes on the blank line, as the last byte of its item
    a_done_lf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_done |-> run_last && out_byte == CHAR_LF)
        else $error("message end not on a closing newline");

    // overflow only ever flags '>' bytes
    a_ovf_gt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && quote_overflow |-> out_byte == CHAR_GT)
        else $error("overflow flag on a non-quote byte");

    // after a message end the next item starts a fresh line, so the next
    // output byte can't be a flagged overflow continuation
    a_ovf_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && message_done ##1 out_valid && quote_overflow
        |-> !$past(quote_overflow))
        else $error("overflow run continued across a message end");

endmodule

bind mboxrd_from_line_quoter mbq_checker u_mbq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .run_last       (run_last),
    .message_done   (message_done),
    .quote_overflow (quote_overflow)
);

@@ tb/mboxrd_from_line_quoter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mboxrd_from_line_quoter_tb
// Self-checking bench for the mboxrd "From " line quoter.
// Drives messages a byte at a time over the input channel. A behavioural
// predictor works out the quoted output bytes per accepted item, and each
// output item is checked against the oldest prediction. Covers directed corner
// cases, random messages, long '>' runs and stretches of output back-pressure.
// ----------------------------------------------------------------------------
module mboxrd_from_line_quoter_tb;
    import mbq_pkg::*;

    localparam int          STALL_LIMIT = 4000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          TAIL_CYCLES = 16;
    localparam logic [39:0] FROM_STR    = "From ";

    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       done;
        logic       ovf;
    } quoted_byte_t;

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       in_valid       = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte        = 8'h00;
    logic       end_of_message = 1'b0;
    logic       out_valid;
    logic       out_ready      = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_done;
    logic       quote_overflow;

    mboxrd_from_line_quoter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .run_last       (run_last),
        .message_done   (message_done),
        .quote_overflow (quote_overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic         st_line_start = 1'b1;
    logic         st_holding    = 1'b0;
    logic         st_cr_held    = 1'b0;
    int unsigned  st_gt_held    = 0;
    int unsigned  st_from_pos   = 0;
    quoted_byte_t step_out[$];
    quoted_byte_t quoted_bytes_due[$];

    int          errors         = 0;
    int          items_sent     = 0;
    int          messages_sent  = 0;
    int          bytes_checked  = 0;
    int          overflow_bytes = 0;
    int          quiet_cycles   = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int unsigned hold_req       = 0;
    int unsigned hold_ack       = 0;
    int          hold_left      = 0;
    logic [7:0]  msg_q[$];

    function automatic logic [7:0] from_char_at(input int unsigned i);
        return FROM_STR[8*(MATCH_LEN-1-i) +: 8];
    endfunction

    task automatic emit_q(input logic [7:0] b, input logic ovf);
        quoted_byte_t r;
        if (step_out.size() < MAX_RESULTS)
        begin
            r.b    = b;
            r.last = 1'b0;
            r.done = 1'b0;
            r.ovf  = ovf;
            step_out.push_back(r);
        end
    endtask

    task automatic flush_held_bytes();
        for (int i = 0; i < st_gt_held; i++)
            emit_q(CHAR_GT, 1'b0);
        for (int i = 0; i < st_from_pos && i < MATCH_LEN; i++)
            emit_q(from_char_at(i), 1'b0);
        st_gt_held  = 0;
        st_from_pos = 0;
        st_holding  = 1'b0;
    endtask

    task automatic plain_text_byte(input logic [7:0] b, input logic eom);
        if (b == CHAR_CR && !eom)
            st_cr_held = 1'b1;
        else
        begin
            emit_q(b, 1'b0);
            if (b == CHAR_LF)
                st_line_start = 1'b1;
        end
    endtask

    task automatic quote_predict(input logic [7:0] b, input logic eom);
        logic consumed;
        consumed = 1'b0;
        step_out.delete();

        if (st_cr_held)
        begin
            st_cr_held = 1'b0;
            if (b == CHAR_LF)
            begin
                emit_q(CHAR_LF, 1'b0);
                st_line_start = 1'b1;
                consumed      = 1'b1;
            end
            else
            begin
                emit_q(CHAR_CR, 1'b0);
                st_line_start = 1'b0;
            end
        end

        if (!consumed)
        begin
            if (st_line_start || st_holding)
            begin
                st_line_start = 1'b0;
                if (st_from_pos == 0 && b == CHAR_GT)
                begin
                    if (st_gt_held >= MAX_QUOTE_DEPTH)
                    begin
                        // run too deep: all of it goes out unquoted
                        for (int i = 0; i <= st_gt_held; i++)
                            emit_q(CHAR_GT, 1'b1);
                        st_gt_held = 0;
                        st_holding = 1'b0;
                    end
                    else
                    begin
                        st_gt_held++;
                        st_holding = 1'b1;
                    end
                end
                else if (st_from_pos < MATCH_LEN && b == from_char_at(st_from_pos))
                begin
                    st_from_pos++;
                    if (st_from_pos >= MATCH_LEN)
                    begin
                        emit_q(CHAR_GT, 1'b0);
                        st_from_pos = MATCH_LEN - 1;
                        flush_held_bytes();
                        emit_q(b, 1'b0);
                    end
                    else
                        st_holding = 1'b1;
                end
                else
                begin
                    flush_held_bytes();
                    plain_text_byte(b, eom);
                end
            end
            else
                plain_text_byte(b, eom);
        end

        if (eom)
        begin
            flush_held_bytes();
            if (b != CHAR_LF)
                emit_q(CHAR_LF, 1'b0);
            emit_q(CHAR_LF, 1'b0);
            st_line_start = 1'b1;
            st_holding    = 1'b0;
            st_gt_held    = 0;
            st_from_pos   = 0;
            st_cr_held    = 1'b0;
        end

        if (step_out.size() > 0)
        begin
            step_out[step_out.size()-1].last = 1'b1;
            if (eom)
                step_out[step_out.size()-1].done = 1'b1;
        end
        foreach (step_out[i])
            quoted_bytes_due.push_back(step_out[i]);
    endtask

    task automatic check_output_byte();
        quoted_byte_t exp_b;
        if (quoted_bytes_due.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected output item, expected none, got byte %h last %b",
                     $time, out_byte, run_last);
            $display("%0t: ... done %b ovf %b", $time, message_done, quote_overflow);
        end
        else
        begin
            exp_b = quoted_bytes_due.pop_front();
            bytes_checked++;
            if (quote_overflow)
                overflow_bytes++;
            if (out_byte !== exp_b.b)
            begin
                errors++;
                $display("%0t: out_byte expected %h got %h", $time, exp_b.b, out_byte);
            end
            if (run_last !== exp_b.last)
            begin
                errors++;
                $display("%0t: run_last expected %b got %b", $time, exp_b.last, run_last);
            end
            if (message_done !== exp_b.done)
            begin
                errors++;
                $display("%0t: message_done expected %b got %b",
                         $time, exp_b.done, message_done);
            end
            if (quote_overflow !== exp_b.ovf)
            begin
                errors++;
                $display("%0t: quote_overflow expected %b got %b",
                         $time, exp_b.ovf, quote_overflow);
            end
        end
    endtask

    // Everything is stable at the falling edge; output is checked before the
    // input item is predicted so a stray output cannot pair with a new item.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_output_byte();
            if (in_valid && in_ready)
                quote_predict(in_byte, end_of_message);
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send_byte(input logic [7:0] b, input logic eom);
        logic taken;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        in_byte        <= b;
        end_of_message <= eom;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic send_str(input string s, input logic eom_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eom_last && (i == s.len() - 1));
        if (eom_last)
            messages_sent++;
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_q.size(); i++)
            send_byte(msg_q[i], i == msg_q.size() - 1);
        messages_sent++;
        msg_q.delete();
    endtask

    // sender pauses until nothing is outstanding
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (quoted_bytes_due.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            msg_q.push_back(s[i]);
    endtask

    task automatic add_noise(input int n, input bit full_range);
        repeat (n)
        begin
            if (full_range)
                msg_q.push_back(8'($urandom_range(0, 255)));
            else
                msg_q.push_back(8'($urandom_range(32, 126)));
        end
    endtask

    task automatic add_gt_run(input int n);
        repeat (n)
            msg_q.push_back(CHAR_GT);
    endtask

    task automatic add_random_line();
        int    kind;
        int    n;
        string from_s;
        kind   = $urandom_range(0, 9);
        from_s = "From ";
        case (kind)
            0, 1, 2:
            begin
                add_gt_run($urandom_range(0, 4));
                add_str(from_s);
                add_noise($urandom_range(0, 6), 1'b0);
            end
            3:
            begin
                // partial "From " followed by a random byte
                add_gt_run($urandom_range(0, 2));
                n = $urandom_range(1, 4);
                add_str(from_s.substr(0, n - 1));
                add_noise(1, 1'b1);
                add_noise($urandom_range(0, 3), 1'b0);
            end
            4:
            begin
                add_noise($urandom_range(1, 4), 1'b0);
                add_str(from_s);
                add_noise($urandom_range(0, 3), 1'b0);
            end
            5: add_noise($urandom_range(1, 8), 1'b1);
            6: ;
            7:
            begin
                add_gt_run($urandom_range(1, 6));
                add_noise($urandom_range(0, 4), 1'b0);
            end
            8:
            begin
                add_noise($urandom_range(0, 3), 1'b0);
                msg_q.push_back(CHAR_CR);
                add_noise($urandom_range(1, 3), 1'b0);
            end
            default: add_noise($urandom_range(1, 10), 1'b0);
        endcase
        case ($urandom_range(0, 5))
            0, 1, 2: msg_q.push_back(CHAR_LF);
            3:
            begin
                msg_q.push_back(CHAR_CR);
                msg_q.push_back(CHAR_LF);
            end
            4: msg_q.push_back(CHAR_CR);
            default: ;
        endcase
    endtask

    task automatic build_random_message();
        repeat ($urandom_range(1, 4))
            add_random_line();
        if (msg_q.size() == 0)
            add_noise(1, 1'b1);
    endtask

    task automatic test_directed();
        send_str("From \n", 1'b1);          // full match, message ends on LF
        send_str(">Fr\r\n", 1'b0);          // quoted partial broken by CRLF
        send_byte(CHAR_CR, 1'b0);           // lone CR
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);             // ends without a newline
        send_byte(CHAR_GT, 1'b0);
        send_byte(CHAR_CR, 1'b1);           // CR on the last byte
        send_str("Fro", 1'b1);              // partial match cut by message end
        send_str(">>From ", 1'b1);          // quoted match on the final byte
        drain_results();
    endtask

    task automatic test_random_messages(input int n_items);
        int target;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            build_random_message();
            send_message();
            if ($urandom_range(0, 7) == 0)
                drain_results();
        end
        drain_results();
    endtask

    task automatic test_long_quote_runs();
        add_gt_run(MAX_QUOTE_DEPTH);        // deepest run that still quotes
        add_str("From a\n");
        add_gt_run(MAX_QUOTE_DEPTH + 1);    // one too many
        add_str("From b\n");
        send_message();
        drain_results();
    endtask

    task automatic test_backpressure();
        hold_req <= hold_req + 1;
        repeat (3)
            add_random_line();
        add_noise(10, 1'b1);
        send_message();
        drain_results();
    endtask

    initial
    begin
        send_idle_pct = 29;
        recv_idle_pct <= 53;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_messages(16);
        test_long_quote_runs();

        send_idle_pct = 53;
        recv_idle_pct <= 29;
        test_random_messages(16);
        test_backpressure();

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        test_random_messages(16);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (quoted_bytes_due.size() != 0)
        begin
            errors += quoted_bytes_due.size();
            $display("%0t: %0d expected output items never arrived",
                     $time, quoted_bytes_due.size());
        end

        $display("summary: %0d input bytes in %0d messages, %0d output bytes checked",
                 items_sent, messages_sent, bytes_checked);
        $display("summary: %0d unquoted overflow bytes, %0d mismatches",
                 overflow_bytes, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
